### rtl/core/pareto_front_filter_defines.svh
// assertion macros shared by the pareto front filter rtl
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef PARETO_FRONT_FILTER_DEFINES_SVH
`define PARETO_FRONT_FILTER_DEFINES_SVH

// same-cycle implication
`define PFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pff_pkg.sv
// types and constants of the pareto front filter
// no dependencies
package pff_pkg;

  localparam int CAPACITY = 64;
  localparam int SIZE_W   = 40;
  localparam int ERR_W    = 32;
  localparam int POS_W    = 6;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = IDX_W + 1;

  typedef struct packed {
    logic [SIZE_W-1:0] candidate_size;
    logic [ERR_W-1:0]  candidate_error;
    logic              last_candidate;
  } cand_t;

  typedef struct packed {
    logic [POS_W-1:0]  entry_position;
    logic [SIZE_W-1:0] entry_size;
    logic [ERR_W-1:0]  entry_error;
    logic              final_entry;
    logic              set_truncated;
  } entry_t;

  // contents of one cell of the chain
  typedef struct packed {
    logic              valid;
    logic              dom;
    logic [SIZE_W-1:0] size;
    logic [ERR_W-1:0]  error;
  } cell_state_t;

  // controls and candidate broadcast to every cell
  typedef struct packed {
    logic              load;
    logic              shift;
    logic              clear;
    logic [SIZE_W-1:0] size;
    logic [ERR_W-1:0]  error;
  } cell_bcast_t;

endpackage

### rtl/core/pff_cell.sv
// one storage and compare cell of the candidate chain
// depends on pff_pkg
module pff_cell import pff_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_bcast_t bc,
  input  logic        write_sel,
  input  logic        pend_hit,
  input  cell_state_t nb,
  output cell_state_t st,
  output logic        beats_new
);

  // a dominates b: no worse in both, strictly better in one
  function automatic logic beats(input logic [SIZE_W-1:0] as_v, input logic [ERR_W-1:0] ae_v,
                                 input logic [SIZE_W-1:0] bs_v, input logic [ERR_W-1:0] be_v);
    beats = (as_v <= bs_v) && (ae_v <= be_v) && ((as_v != bs_v) || (ae_v != be_v));
  endfunction

  logic mark_me;

  assign mark_me   = bc.load && st.valid && beats(bc.size, bc.error, st.size, st.error);
  assign beats_new = st.valid && beats(st.size, st.error, bc.size, bc.error);

  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
      st.dom   <= 1'b0;
    end else if (bc.clear) begin
      st.valid <= 1'b0;
      st.dom   <= 1'b0;
    end else if (bc.shift) begin
      st <= nb;
    end else if (write_sel) begin
      st.valid <= 1'b1;
      st.dom   <= 1'b0;
      st.size  <= bc.size;
      st.error <= bc.error;
    end else if (mark_me || pend_hit) begin
      st.dom <= 1'b1;
    end
  end

endmodule

### rtl/core/pareto_front_filter.sv
// sequence: candidates load one per cycle while in the load state; after the last transfer a
// settle state, then the chain shifts one cell per cycle toward the head, emitting survivors
// in load order, until no survivor remains and the chain is cleared
// the shift chain (one cell per cycle) sets the emission rate; output stalls pause it
// reset: synchronous, empties the chain, zeroes the load count and the truncation flag
`include "pareto_front_filter_defines.svh"

module pareto_front_filter import pff_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  cand_t  in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output entry_t out_data
);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_SETTLE = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]          state;
  logic [CNT_W-1:0]    count;
  logic                overflow;
  logic [CNT_W-1:0]    pos_cnt;

  // dominance of the newest candidate, registered and folded into its cell in the cycle after its load
  logic                pend_valid;
  logic [IDX_W-1:0]    pend_idx;
  logic [CAPACITY-1:0] pend_bits;

  cell_state_t         cells [CAPACITY+1];
  cell_bcast_t         bc;
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] surv_vec;
  logic [CAPACITY-1:0] beats_vec;

  logic accept_in;
  logic load_ok;
  logic slot_free;
  logic any_surv;
  logic rest_surv;
  logic emit_go;
  logic emit_out;
  logic emit_done;
  logic pend_any;

  // handshake and chain control
  assign in_ready  = (state == ST_LOAD);
  assign accept_in = in_valid && in_ready;
  assign load_ok   = accept_in && (count < CNT_W'(CAPACITY));   // full store drops the transfer
  assign slot_free = !out_valid || out_ready;
  assign any_surv  = |surv_vec;
  assign rest_surv = |surv_vec[CAPACITY-1:1];
  // shift unless a survivor sits at the head and the output register is busy
  assign emit_go   = (state == ST_EMIT) && any_surv && (!surv_vec[0] || slot_free);
  assign emit_out  = emit_go && surv_vec[0];
  // nothing left to emit: drop the non-survivors
  assign emit_done = (state == ST_EMIT) && !any_surv;
  assign pend_any  = pend_valid && (|pend_bits);

  assign bc.load  = load_ok;
  assign bc.shift = emit_go;
  assign bc.clear = emit_done;
  assign bc.size  = in_data.candidate_size;
  assign bc.error = in_data.candidate_error;

  // tail of the chain feeds in empty cells
  assign cells[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic write_sel;
    logic pend_hit;

    assign write_sel = load_ok && (count[IDX_W-1:0] == IDX_W'(i));
    assign pend_hit  = pend_any && (pend_idx == IDX_W'(i));

    pff_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .bc        (bc),
      .write_sel (write_sel),
      .pend_hit  (pend_hit),
      .nb        (cells[i+1]),
      .st        (cells[i]),
      .beats_new (beats_vec[i])
    );

    assign valid_vec[i] = cells[i].valid;
    assign surv_vec[i]  = cells[i].valid && !cells[i].dom;
  end

  // control path
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      overflow   <= 1'b0;
      pos_cnt    <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= load_ok;
      unique case (state)
        ST_LOAD: begin
          if (accept_in) begin
            if (load_ok) begin
              count <= count + CNT_W'(1);
            end else begin
              overflow <= 1'b1;
            end
            if (in_data.last_candidate) begin
              state <= ST_SETTLE;
            end
          end
        end
        ST_SETTLE: begin
          // the last load's mark lands in its cell here
          state   <= ST_EMIT;
          pos_cnt <= '0;
        end
        ST_EMIT: begin
          if (emit_go) begin
            pos_cnt <= pos_cnt + CNT_W'(1);
          end
          if (emit_done) begin
            state    <= ST_LOAD;
            count    <= '0;
            overflow <= 1'b0;
            pos_cnt  <= '0;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // pending mark payload
  always_ff @(posedge clk) begin
    pend_bits <= beats_vec;
    if (load_ok) begin
      pend_idx <= count[IDX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_out) begin
      out_data.entry_position <= POS_W'(pos_cnt);
      out_data.entry_size     <= cells[0].size;
      out_data.entry_error    <= cells[0].error;
      out_data.final_entry    <= !rest_surv;
      out_data.set_truncated  <= overflow;
    end
  end

  // checks
  `PFF_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "load count above capacity")
  `PFF_ASSERT_NOW(a_fill_matches, state == ST_LOAD, $countones(valid_vec) == int'(count),
    "occupied cells disagree with load count")
  `PFF_ASSERT_NEXT(a_head_emits, emit_out,
    out_valid && (out_data.entry_position == $past(POS_W'(pos_cnt))),
    "head survivor not transferred to output register")
  `PFF_ASSERT_NEXT(a_set_cleared, emit_done, (valid_vec == '0) && (count == '0) && !overflow,
    "chain not empty after emission")

endmodule

### verif/tb.sv
// self-checking bench for pareto_front_filter: candidate sets go in, survivors are checked
// against a dominance predictor kept here; depends on pff_pkg and the filter rtl only
module tb;
  import pff_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 210;
  localparam int HOLD_CYCLES = 600;
  localparam logic [SIZE_W-1:0] SIZE_TOP = {SIZE_W{1'b1}};
  localparam logic [ERR_W-1:0]  ERR_TOP  = {ERR_W{1'b1}};

  logic   clk;
  logic   rst;
  logic   in_valid;
  logic   in_ready;
  cand_t  in_data;
  logic   out_valid;
  logic   out_ready;
  entry_t out_data;

  pareto_front_filter uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // one stimulus row: a candidate, plus a survivor typed in by hand where obvious
  typedef struct {
    cand_t  cand;
    logic   typed;
    entry_t want;
  } cand_row_t;

  cand_row_t directed_rows[$];

  // predictor state: the stored set and its dominance marks
  logic [SIZE_W-1:0] kept_size[CAPACITY];
  logic [ERR_W-1:0]  kept_error[CAPACITY];
  bit                beaten[CAPACITY];
  int unsigned       kept_count = 0;
  bit                dropped_any = 1'b0;

  entry_t survivors[$];   // front emitted by the set just closed
  entry_t awaited[$];     // survivors still to come out of the block

  int   items_sent = 0;
  int   mismatches = 0;
  int   cycles = 0;
  bit   no_gaps = 1'b0;
  logic hold_off = 1'b0;

  // a dominates b: no worse in both objectives and not identical
  function automatic bit dominates(input logic [SIZE_W-1:0] as, input logic [ERR_W-1:0] ae,
                                   input logic [SIZE_W-1:0] bs, input logic [ERR_W-1:0] be);
    return (as <= bs) && (ae <= be) && ((as != bs) || (ae != be));
  endfunction

  // fold one transferred candidate into the set; on the last one, build the front
  function automatic void sift_candidate(input cand_t c);
    bit     mine;
    entry_t e;
    survivors.delete();
    if (kept_count < CAPACITY) begin
      mine = 1'b0;
      for (int i = 0; i < kept_count; i++) begin
        if (dominates(c.candidate_size, c.candidate_error, kept_size[i], kept_error[i]))
          beaten[i] = 1'b1;
        if (dominates(kept_size[i], kept_error[i], c.candidate_size, c.candidate_error))
          mine = 1'b1;
      end
      kept_size[kept_count]  = c.candidate_size;
      kept_error[kept_count] = c.candidate_error;
      beaten[kept_count]     = mine;
      kept_count++;
    end else begin
      // store full: candidate is dropped and the set is marked truncated
      dropped_any = 1'b1;
    end
    if (c.last_candidate) begin
      for (int i = 0; i < kept_count; i++) begin
        if (!beaten[i]) begin
          e.entry_position = POS_W'(i);
          e.entry_size     = kept_size[i];
          e.entry_error    = kept_error[i];
          e.final_entry    = 1'b0;
          e.set_truncated  = dropped_any;
          survivors.insert(survivors.size(), e);
        end
      end
      if (survivors.size() > 0)
        survivors[survivors.size()-1].final_entry = 1'b1;
      for (int i = 0; i < CAPACITY; i++)
        beaten[i] = 1'b0;
      kept_count  = 0;
      dropped_any = 1'b0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // random candidate; small values dominate often so ties and dominance are common
  function automatic cand_t make_candidate(input logic lst);
    cand_t c;
    int    mode;
    mode = $urandom_range(0, 9);
    c.last_candidate = lst;
    if (mode < 6) begin
      c.candidate_size  = SIZE_W'($urandom_range(0, 15));
      c.candidate_error = ERR_W'($urandom_range(0, 15));
    end else if (mode < 8) begin
      c.candidate_size  = SIZE_W'({$urandom(), $urandom()});
      c.candidate_error = $urandom();
    end else if (mode == 8) begin
      c.candidate_size  = $urandom_range(0, 1) ? SIZE_TOP : '0;
      c.candidate_error = $urandom_range(0, 1) ? ERR_TOP : '0;
    end else begin
      c.candidate_size  = SIZE_TOP - SIZE_W'($urandom_range(0, 7));
      c.candidate_error = ERR_TOP - ERR_W'($urandom_range(0, 7));
    end
    return c;
  endfunction

  function automatic void add_row(input logic [SIZE_W-1:0] sz, input logic [ERR_W-1:0] er,
                                  input logic lst, input logic typed, input entry_t want);
    cand_row_t r;
    r.cand.candidate_size  = sz;
    r.cand.candidate_error = er;
    r.cand.last_candidate  = lst;
    r.typed = typed;
    r.want  = want;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
  endtask

  // offer one candidate, hold it until the transfer, then update the prediction
  task automatic send_cand(input cand_t c, input logic typed, input entry_t want);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    sift_candidate(c);
    if (typed) begin
      if (c.last_candidate)
        awaited.insert(awaited.size(), want);
    end else begin
      foreach (survivors[i])
        awaited.insert(awaited.size(), survivors[i]);
    end
  endtask

  // stimulus: directed sets first, then random sets, then drain and decide
  initial begin : stimulus
    int                len;
    int                set_idx;
    bit                stair;
    cand_t             c;
    logic [SIZE_W-1:0] stair_size;
    logic [ERR_W-1:0]  stair_err;
    int                step;

    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;

    // single candidate at the top of both ranges: it survives alone
    add_row(SIZE_TOP, ERR_TOP, 1'b1, 1'b1, entry_t'{6'd0, SIZE_TOP, ERR_TOP, 1'b1, 1'b0});
    // single candidate at zero
    add_row('0, '0, 1'b1, 1'b1, entry_t'{6'd0, 40'd0, 32'd0, 1'b1, 1'b0});
    // exact duplicates both survive
    add_row(40'd100, 32'd5, 1'b0, 1'b0, '0);
    add_row(40'd100, 32'd5, 1'b1, 1'b0, '0);
    // newer candidate knocks out an older one, then a later one is beaten on arrival
    add_row(40'd50, 32'd10, 1'b0, 1'b0, '0);
    add_row(40'd40, 32'd10, 1'b0, 1'b0, '0);
    add_row(40'd40, 32'd20, 1'b1, 1'b0, '0);
    // pure trade-off: nobody dominates
    add_row(40'd10, 32'd1000, 1'b0, 1'b0, '0);
    add_row(40'd1000, 32'd10, 1'b0, 1'b0, '0);
    add_row(40'd500, 32'd500, 1'b1, 1'b0, '0);
    // first candidate beats the last one: only position zero comes out
    add_row(40'd1, 32'd1, 1'b0, 1'b0, '0);
    add_row(40'd2, 32'd1, 1'b1, 1'b1, entry_t'{6'd0, 40'd1, 32'd1, 1'b1, 1'b0});
    // opposite extremes of the two objectives
    add_row('0, ERR_TOP, 1'b0, 1'b0, '0);
    add_row(SIZE_TOP, '0, 1'b1, 1'b0, '0);
    // alternating bit patterns
    add_row(40'hAAAAAAAAAA, 32'h55555555, 1'b0, 1'b0, '0);
    add_row(40'h5555555555, 32'hAAAAAAAA, 1'b1, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_cand(directed_rows[i].cand, directed_rows[i].typed, directed_rows[i].want);

    // random sets: mostly short, one that exactly fills the store, one that overflows it
    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      if (set_idx == 2)
        len = CAPACITY;
      else if (set_idx == 5)
        len = CAPACITY + 3;
      else if ($urandom_range(0, 7) == 0)
        len = $urandom_range(9, 24);
      else
        len = $urandom_range(1, 8);
      // staircase sets keep most candidates on the front
      stair   = (set_idx == 2) || ($urandom_range(0, 3) == 0);
      no_gaps = ($urandom_range(0, 3) == 0);
      stair_size = SIZE_W'($urandom_range(0, 1000));
      stair_err  = ERR_TOP - ERR_W'($urandom_range(0, 1000));
      for (int k = 0; k < len; k++) begin
        c = make_candidate(k == len - 1);
        if (stair) begin
          step = $urandom_range(0, 40);
          stair_size += SIZE_W'(step);
          step = $urandom_range(0, 40);
          stair_err  -= ERR_W'(step);
          c.candidate_size  = stair_size;
          c.candidate_error = stair_err;
        end
        send_cand(c, 1'b0, '0);
      end
      set_idx++;
    end
    in_valid <= 1'b0;

    while (awaited.size() != 0) @(posedge clk);
    // let any stray entry show up before the verdict
    repeat (CAPACITY + 8) @(posedge clk);
    if (mismatches == 0)
      $display("** pareto_front_filter: PASSED **");
    else
      $display("** pareto_front_filter: FAILED **");
    $finish;
  end

  // receiver: runs of ready, then stalls of random length
  initial begin : receiver
    int n;
    out_ready <= 1'b0;
    forever begin
      n = $urandom_range(1, 40);
      repeat (n) begin
        out_ready <= !hold_off;
        @(posedge clk);
      end
      n = pick_gap();
      repeat (n) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // long receiver hold-off while the sender keeps offering: the chain fills and
  // the input side has to stall behind a blocked emission
  initial begin : backpressure
    wait (items_sent >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // compare every output transfer with the oldest awaited survivor
  always @(posedge clk) begin : front_check
    entry_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        report_mismatch("entry with nothing awaited", 64'(out_data.entry_size), '0);
      end else begin
        want = awaited.pop_front();
        if (out_data.entry_position != want.entry_position)
          report_mismatch("entry_position", 64'(out_data.entry_position),
                          64'(want.entry_position));
        if (out_data.entry_size != want.entry_size)
          report_mismatch("entry_size", 64'(out_data.entry_size), 64'(want.entry_size));
        if (out_data.entry_error != want.entry_error)
          report_mismatch("entry_error", 64'(out_data.entry_error), 64'(want.entry_error));
        if (out_data.final_entry != want.final_entry)
          report_mismatch("final_entry", 64'(out_data.final_entry), 64'(want.final_entry));
        if (out_data.set_truncated != want.set_truncated)
          report_mismatch("set_truncated", 64'(out_data.set_truncated),
                          64'(want.set_truncated));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** pareto_front_filter: FAILED **");
      $finish;
    end
  end

endmodule
